@@ design/rhc_pkg.sv @@
// Shared types and constants for the relaxed header canonicalizer.
package rhc_pkg;

	localparam int unsigned COUNT_BITS = 16;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned LIMIT_W    = 16;
	localparam int unsigned REC_BYTES  = 3;
	localparam int unsigned REC_DEPTH  = 4;
	localparam int unsigned REC_PTR_W  = $clog2(REC_DEPTH);

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_BIT = 8'h20;
	localparam int unsigned RESERVE = 3;

	typedef struct packed {
		logic                         last;
		logic [1:0]                   cnt;
		logic [REC_BYTES-1:0][7:0]    bytes;
	} rec_t;

endpackage

@@ design/relaxed_header_canonicalizer.sv @@
// Relaxed header canonicalizer top level: config registers, front end, queue, back end.
// Input side is a queue: drive one item with push; it is taken at an edge where full is
// low. An item carries one raw byte of a header name or value, or only the end mark.
// Result side is a queue too: while empty is low the oldest result beat sits on out_byte,
// final_res, error and length; pop takes it. The last beat of each header has final_res.
// A result reaches the outputs through the record queue and the output register.
// Items are taken one per cycle while full is low; the back end sends one beat per
// cycle unless the receiver stalls, so an item holds it until its beats are sent, and
// a four-record queue between the two halves soaks up these bursts before full rises.
// Items that yield no byte and no end mark skip the back end; after a length error each
// further record of that header still passes through the back end and yields no beat.
// When the receiver stalls, the output beat holds, the queue fills and full
// rises; nothing is lost. Reset clears all header state, empties the queue and loads
// output_limit with 1024 and append_line_end with 0. Registers sit on the APB port at
// byte address 0 (output_limit) and 4 (append_line_end); write them only while idle.
module relaxed_header_canonicalizer import rhc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	input  logic               is_value,
	input  logic               has_byte,
	input  logic               last,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         out_byte,
	output logic               final_res,
	output logic               error,
	output logic [LEN_W-1:0]   length
);

	localparam logic REG_OUTPUT_LIMIT    = 1'b0;
	localparam logic REG_APPEND_LINE_END = 1'b1;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

	logic [LIMIT_W-1:0] output_limit_q;
	logic               append_q;
	logic               cfg_wr, take;
	rec_t               rec_in, rec_head;
	logic               rec_push, rec_pop, rec_empty, rec_full;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_limit_q <= LIMIT_RESET;
			append_q       <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_OUTPUT_LIMIT:    output_limit_q <= pwdata[LIMIT_W-1:0];
				REG_APPEND_LINE_END: append_q <= pwdata[0];
				default:             append_q <= append_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_OUTPUT_LIMIT:    prdata = 32'(output_limit_q);
			REG_APPEND_LINE_END: prdata = 32'(append_q);
			default:             prdata = '0;
		endcase
	end

	assign full = rec_full;
	assign take = push && !rec_full;

	rhc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.is_value  (is_value),
		.has_byte  (has_byte),
		.last      (last),
		.take      (take),
		.rec       (rec_in),
		.rec_push  (rec_push)
	);

	rhc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec_in),
		.pop    (rec_pop),
		.rdata  (rec_head),
		.empty  (rec_empty),
		.full   (rec_full)
	);

	rhc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.rec             (rec_head),
		.rec_valid       (!rec_empty),
		.rec_pop         (rec_pop),
		.output_limit    (output_limit_q),
		.append_line_end (append_q),
		.empty           (empty),
		.pop             (pop),
		.out_byte        (out_byte),
		.final_res       (final_res),
		.error           (error),
		.length          (length)
	);

	a_error_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error) |-> final_res)
		else $error("error beat without final mark");

	a_error_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error) |-> (out_byte == 8'h00))
		else $error("error beat carries a byte");

	a_pop_needs_record: assert property (@(posedge clk) disable iff (!arst_n)
		rec_pop |-> !rec_empty)
		else $error("back end consumed a record from an empty queue");

endmodule

@@ design/rhc_front.sv @@
// Front end: classifies each input beat and builds the bytes it produces.
module rhc_front import rhc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       is_value,
	input  logic       has_byte,
	input  logic       last,
	input  logic       take,
	output rec_t       rec,
	output logic       rec_push
);

	typedef enum logic [1:0] {BRK_NONE, BRK_CR, BRK_LINE} brk_t;

	brk_t hb_q, hb_d;
	logic sp_q, sp_d;
	logic colon_q, colon_d;
	logic lead_q, lead_d;
	logic ended_q, ended_d;
	logic [1:0] n_d;
	logic [REC_BYTES-1:0][7:0] bytes_d;
	logic [7:0] c;
	logic blank;

	assign blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB);

	always_comb begin
		hb_d    = hb_q;
		sp_d    = sp_q;
		colon_d = colon_q;
		lead_d  = lead_q;
		ended_d = ended_q;
		n_d     = 2'd0;
		bytes_d = '0;
		c       = data_byte;
		if (has_byte) begin
			if (!is_value) begin
				if (!colon_d) begin
					if (c >= CH_UP_A && c <= CH_UP_Z)
						c = c | CASE_BIT;
					bytes_d[n_d] = c;
					n_d = n_d + 2'd1;
				end
			end else if (!ended_d) begin
				if (!colon_d) begin
					colon_d = 1'b1;
					bytes_d[n_d] = CH_COLON;
					n_d = n_d + 2'd1;
				end
				if (hb_d == BRK_LINE) begin
					hb_d = BRK_NONE;
					if (blank)
						sp_d = 1'b1;
					else
						ended_d = 1'b1;
				end else if (hb_d == BRK_CR && data_byte == CH_LF) begin
					hb_d = BRK_LINE;
				end else begin
					if (hb_d == BRK_CR) begin
						hb_d = BRK_NONE;
						if (sp_d) begin
							sp_d = 1'b0;
							bytes_d[n_d] = CH_SPACE;
							n_d = n_d + 2'd1;
						end
						bytes_d[n_d] = CH_CR;
						n_d = n_d + 2'd1;
					end
					if (blank) begin
						if (!lead_d)
							sp_d = 1'b1;
					end else if (data_byte == CH_CR) begin
						lead_d = 1'b0;
						hb_d = BRK_CR;
					end else if (data_byte == CH_LF) begin
						lead_d = 1'b0;
						hb_d = BRK_LINE;
					end else begin
						lead_d = 1'b0;
						if (sp_d) begin
							sp_d = 1'b0;
							bytes_d[n_d] = CH_SPACE;
							n_d = n_d + 2'd1;
						end
						bytes_d[n_d] = data_byte;
						n_d = n_d + 2'd1;
					end
				end
			end
		end
		if (last) begin
			if (!colon_d) begin
				colon_d = 1'b1;
				bytes_d[n_d] = CH_COLON;
				n_d = n_d + 2'd1;
			end
			if (hb_d == BRK_CR && !ended_d) begin
				if (sp_d) begin
					bytes_d[n_d] = CH_SPACE;
					n_d = n_d + 2'd1;
				end
				bytes_d[n_d] = CH_CR;
				n_d = n_d + 2'd1;
			end
			hb_d    = BRK_NONE;
			sp_d    = 1'b0;
			colon_d = 1'b0;
			lead_d  = 1'b1;
			ended_d = 1'b0;
		end
	end

	assign rec.last  = last;
	assign rec.cnt   = n_d;
	assign rec.bytes = bytes_d;
	assign rec_push  = take && ((n_d != 2'd0) || last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_q    <= BRK_NONE;
			sp_q    <= 1'b0;
			colon_q <= 1'b0;
			lead_q  <= 1'b1;
			ended_q <= 1'b0;
		end else if (take) begin
			hb_q    <= hb_d;
			sp_q    <= sp_d;
			colon_q <= colon_d;
			lead_q  <= lead_d;
			ended_q <= ended_d;
		end
	end

endmodule

@@ design/rhc_fifo.sv @@
// Short record queue between the front end and the back end.
module rhc_fifo import rhc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t wdata,
	input  logic pop,
	output rec_t rdata,
	output logic empty,
	output logic full
);

	rec_t mem_q [REC_DEPTH];
	logic [REC_PTR_W-1:0] wr_ptr_q;
	logic [REC_PTR_W-1:0] rd_ptr_q;
	logic [REC_PTR_W:0]   fill_q;

	assign empty = (fill_q == '0);
	assign full  = (fill_q == (REC_PTR_W+1)'(REC_DEPTH));
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

@@ design/rhc_back.sv @@
// Back end: counts, limits and sends the canonical bytes one beat per cycle unless the receiver stalls.
module rhc_back import rhc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  rec_t               rec,
	input  logic               rec_valid,
	output logic               rec_pop,
	input  logic [LIMIT_W-1:0] output_limit,
	input  logic               append_line_end,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         out_byte,
	output logic               final_res,
	output logic               error,
	output logic [LEN_W-1:0]   length
);

	localparam int unsigned CAP_W = ((COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W) + 1;
	localparam logic [CAP_W-1:0] CAP_CEIL = CAP_W'((64'd1 << COUNT_BITS) - 64'd3);

	logic [COUNT_BITS-1:0] count_q, cnt_d, cnt_inc;
	logic                  failed_q, fail_d;
	logic [2:0]            k_q, k_d, k_inc, nc;
	logic [CAP_W-1:0]      lim_ext, cap;
	logic                  load, step, emit, done;
	logic [7:0]            ob;
	logic                  ofin, oerr;
	logic [LEN_W-1:0]      olen;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  final_q, error_q;
	logic [LEN_W-1:0]      length_q;

	assign lim_ext = CAP_W'(output_limit);
	always_comb begin
		cap = (lim_ext >= CAP_W'(RESERVE)) ? lim_ext - CAP_W'(RESERVE) : '0;
		if (cap > CAP_CEIL)
			cap = CAP_CEIL;
	end

	assign load    = !out_valid_q || pop;
	assign step    = load && rec_valid;
	assign cnt_inc = count_q + 1'b1;
	assign k_inc   = k_q + 3'd1;
	assign nc      = {1'b0, rec.cnt};

	always_comb begin
		emit   = 1'b0;
		ob     = 8'h00;
		ofin   = 1'b0;
		oerr   = 1'b0;
		olen   = LEN_W'(count_q);
		cnt_d  = count_q;
		fail_d = failed_q;
		k_d    = k_q;
		done   = 1'b0;
		if (step) begin
			if (failed_q) begin
				done = 1'b1;
				if (rec.last) begin
					fail_d = 1'b0;
					cnt_d  = '0;
				end
			end else if (k_q < nc) begin
				emit = 1'b1;
				if (CAP_W'(count_q) >= cap) begin
					ofin = 1'b1;
					oerr = 1'b1;
					done = 1'b1;
					if (rec.last) begin
						cnt_d = '0;
					end else begin
						fail_d = 1'b1;
					end
				end else begin
					ob    = rec.bytes[k_q[1:0]];
					cnt_d = cnt_inc;
					olen  = LEN_W'(cnt_inc);
					k_d   = k_inc;
					if (k_inc == nc && !(rec.last && append_line_end)) begin
						done = 1'b1;
						ofin = rec.last;
						if (rec.last)
							cnt_d = '0;
					end
				end
			end else if (append_line_end) begin
				emit = 1'b1;
				olen = LEN_W'(cnt_inc);
				if (k_q == nc) begin
					ob    = CH_CR;
					cnt_d = cnt_inc;
					k_d   = k_inc;
				end else begin
					ob    = CH_LF;
					ofin  = 1'b1;
					done  = 1'b1;
					cnt_d = '0;
				end
			end else begin
				emit  = 1'b1;
				ofin  = 1'b1;
				done  = 1'b1;
				cnt_d = '0;
			end
			if (done)
				k_d = '0;
		end
	end

	assign rec_pop   = done;
	assign empty     = !out_valid_q;
	assign out_byte  = out_byte_q;
	assign final_res = final_q;
	assign error     = error_q;
	assign length    = length_q;

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q <= ob;
			final_q    <= ofin;
			error_q    <= oerr;
			length_q   <= olen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
			failed_q    <= 1'b0;
			k_q         <= '0;
		end else begin
			if (load)
				out_valid_q <= step && emit;
			count_q  <= cnt_d;
			failed_q <= fail_d;
			k_q      <= k_d;
		end
	end

endmodule
